/* hdl/rcl_pkg.sv */
`timescale 1ns / 1ps
package rcl_pkg;

   // Array and element geometry
   localparam int MAX_LEN    = 1024;
   localparam int POS_W      = 10;
   localparam int LEN_W      = 11;
   localparam int CNT_W      = 12;
   localparam int ELEM_W     = 32;
   localparam int NUM_LEVELS = 11;
   localparam int LVL_W      = 4;
   localparam int LVL_DEPTH  = NUM_LEVELS * MAX_LEN;
   localparam int ADDR_W     = LVL_W + POS_W;

   // Sign bit flip that turns a two's complement element into an ordered key
   localparam logic [ELEM_W-1:0] KEY_FLIP = {1'b1, {(ELEM_W-1){1'b0}}};

   // Request modes
   localparam logic [1:0] MODE_LOAD  = 2'd0;
   localparam logic [1:0] MODE_BUILD = 2'd1;
   localparam logic [1:0] MODE_QUERY = 2'd2;

   // Response kinds
   localparam logic KIND_BUILD = 1'b0;
   localparam logic KIND_QUERY = 1'b1;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      logic [ELEM_W-1:0] data;
   } lvl_wr_type;

   typedef struct packed {
      logic             valid;
      logic             kind;
      logic [LEN_W-1:0] count;
   } result_type;

endpackage

/* hdl/rcl_req_if.sv */
`timescale 1ns / 1ps
interface rcl_req_if;
   logic                            valid;
   logic                            ready;
   logic [1:0]                      mode;
   logic [rcl_pkg::POS_W-1:0]       position;
   logic signed [rcl_pkg::ELEM_W-1:0] value;
   logic [rcl_pkg::POS_W-1:0]       range_low;
   logic [rcl_pkg::POS_W-1:0]       range_high;

   modport source (output valid, mode, position, value, range_low, range_high, input ready);
   modport sink (input valid, mode, position, value, range_low, range_high, output ready);
endinterface

/* hdl/rcl_rsp_if.sv */
`timescale 1ns / 1ps
interface rcl_rsp_if;
   logic                      valid;
   logic                      ready;
   logic                      kind;
   logic [rcl_pkg::LEN_W-1:0] count;

   modport source (output valid, kind, count, input ready);
   modport sink (input valid, kind, count, output ready);
endinterface

/* hdl/rcl_raw_mem.sv */
`timescale 1ns / 1ps
module rcl_raw_mem (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [rcl_pkg::POS_W-1:0]  wr_addr,
   input  logic [rcl_pkg::ELEM_W-1:0] wr_data,
   input  logic [rcl_pkg::POS_W-1:0]  rd_addr,
   output logic [rcl_pkg::ELEM_W-1:0] rd_data
);

   logic [rcl_pkg::ELEM_W-1:0] mem [0:rcl_pkg::MAX_LEN-1];
   logic [rcl_pkg::ELEM_W-1:0] rd_data_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* hdl/rcl_level_mem.sv */
`timescale 1ns / 1ps
module rcl_level_mem (
   input  logic                       clock,
   input  rcl_pkg::lvl_wr_type        wr,
   input  logic [rcl_pkg::ADDR_W-1:0] rd_addr_a,
   input  logic [rcl_pkg::ADDR_W-1:0] rd_addr_b,
   output logic [rcl_pkg::ELEM_W-1:0] rd_data_a,
   output logic [rcl_pkg::ELEM_W-1:0] rd_data_b
);

   logic [rcl_pkg::ELEM_W-1:0] mem [0:rcl_pkg::LVL_DEPTH-1];
   logic [rcl_pkg::ELEM_W-1:0] rd_a_ff;
   logic [rcl_pkg::ELEM_W-1:0] rd_b_ff;

   // One write port, two registered read ports
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      rd_a_ff <= mem[rd_addr_a];
      rd_b_ff <= mem[rd_addr_b];
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

/* hdl/rcl_engine.sv */
`timescale 1ns / 1ps
module rcl_engine (
   input  logic                       clock,
   input  logic                       reset,
   rcl_req_if.sink                    req_ch,
   input  logic [rcl_pkg::LEN_W-1:0]  length,
   input  logic                       res_take,
   output rcl_pkg::result_type        res
);

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_CP_RD  = 4'd1;
   localparam logic [3:0] S_CP_WR  = 4'd2;
   localparam logic [3:0] S_MG_LVL = 4'd3;
   localparam logic [3:0] S_MG_BLK = 4'd4;
   localparam logic [3:0] S_MG_RD  = 4'd5;
   localparam logic [3:0] S_MG_WR  = 4'd6;
   localparam logic [3:0] S_Q_SIZE = 4'd7;
   localparam logic [3:0] S_Q_RD   = 4'd8;
   localparam logic [3:0] S_Q_CMP  = 4'd9;
   localparam logic [3:0] S_DONE   = 4'd10;

   localparam int CW = rcl_pkg::CNT_W;
   localparam int LW = rcl_pkg::LVL_W;
   localparam int PW = rcl_pkg::POS_W;

   logic [3:0]                  state_ff, state_in;
   logic [CW-1:0]               n_ff, n_in;
   logic [CW-1:0]               built_ff, built_in;
   logic [LW-1:0]               top_ff, top_in;
   logic [LW-1:0]               lvl_ff, lvl_in;
   logic [CW-1:0]               base_ff, base_in;
   logic [CW-1:0]               ia_ff, ia_in;
   logic [CW-1:0]               jb_ff, jb_in;
   logic [CW-1:0]               alen_ff, alen_in;
   logic [CW-1:0]               blen_ff, blen_in;
   logic [CW-1:0]               idx_ff, idx_in;
   logic [rcl_pkg::ELEM_W-1:0]  key_ff, key_in;
   logic [CW-1:0]               qhi_ff, qhi_in;
   logic [CW-1:0]               qi_ff, qi_in;
   logic [LW-1:0]               qk_ff, qk_in;
   logic [CW-1:0]               slo_ff, slo_in;
   logic [CW-1:0]               shi_ff, shi_in;
   logic [CW-1:0]               mid_ff, mid_in;
   logic [rcl_pkg::LEN_W-1:0]   total_ff, total_in;
   logic                        kind_ff, kind_in;

   logic                        acc;
   logic [CW-1:0]               half;
   logic [CW-1:0]               rest;
   logic [CW-1:0]               a_len;
   logic [CW-1:0]               b_rest;
   logic [CW-1:0]               sz;
   logic [CW-1:0]               hi_clip;
   logic [CW-1:0]               mid_c;
   logic [CW-1:0]               qi_next;
   logic [CW-1:0]               out_pos;
   logic [CW-1:0]               b_pos;
   logic [CW-1:0]               a_pos;
   logic [CW-1:0]               q_pos;
   logic                        take_b;

   logic [rcl_pkg::ELEM_W-1:0]  raw_q;
   logic [rcl_pkg::ELEM_W-1:0]  lvl_qa;
   logic [rcl_pkg::ELEM_W-1:0]  lvl_qb;
   rcl_pkg::lvl_wr_type         lvl_wr;
   logic [rcl_pkg::ADDR_W-1:0]  lvl_rd_a;
   logic [rcl_pkg::ADDR_W-1:0]  lvl_rd_b;

   assign req_ch.ready = (state_ff == S_IDLE);
   assign acc          = req_ch.valid && req_ch.ready;

   rcl_raw_mem u_raw (
      .clock   (clock),
      .wr_en   (acc && (req_ch.mode == rcl_pkg::MODE_LOAD)),
      .wr_addr (req_ch.position),
      .wr_data (req_ch.value),
      .rd_addr (idx_ff[PW-1:0]),
      .rd_data (raw_q)
   );

   rcl_level_mem u_lvl (
      .clock     (clock),
      .wr        (lvl_wr),
      .rd_addr_a (lvl_rd_a),
      .rd_addr_b (lvl_rd_b),
      .rd_data_a (lvl_qa),
      .rd_data_b (lvl_qb)
   );

   // Shared address arithmetic
   always_comb begin
      half    = CW'(1) << lvl_ff;
      rest    = n_ff - base_ff;
      a_len   = (rest < half) ? rest : half;
      b_rest  = ((rest - a_len) < half) ? (rest - a_len) : half;
      sz      = CW'(2) << qk_ff;
      hi_clip = ({2'b00, req_ch.range_high} > (built_ff - CW'(1))) ?
                (built_ff - CW'(1)) : {2'b00, req_ch.range_high};
      mid_c   = (slo_ff + shi_ff) >> 1;
      qi_next = qi_ff + (CW'(1) << qk_ff);
      out_pos = base_ff + ia_ff + jb_ff;
      a_pos   = base_ff + ia_ff;
      b_pos   = base_ff + alen_ff + jb_ff;
      q_pos   = qi_ff + mid_c;
      take_b  = (jb_ff < blen_ff) && ((ia_ff == alen_ff) || (lvl_qb < lvl_qa));
   end

   // Level memory ports
   always_comb begin
      lvl_wr.en   = (state_ff == S_CP_WR) || (state_ff == S_MG_WR);
      if (state_ff == S_CP_WR) begin
         lvl_wr.addr = {LW'(0), idx_ff[PW-1:0]};
         lvl_wr.data = raw_q ^ rcl_pkg::KEY_FLIP;
      end else begin
         lvl_wr.addr = {lvl_ff + LW'(1), out_pos[PW-1:0]};
         lvl_wr.data = take_b ? lvl_qb : lvl_qa;
      end
      if (state_ff == S_Q_RD) begin
         lvl_rd_a = {qk_ff, q_pos[PW-1:0]};
      end else begin
         lvl_rd_a = {lvl_ff, a_pos[PW-1:0]};
      end
      lvl_rd_b = {lvl_ff, b_pos[PW-1:0]};
   end

   // Sequencer: copy, merge levels, block search
   always_comb begin
      state_in = state_ff;
      n_in     = n_ff;
      built_in = built_ff;
      top_in   = top_ff;
      lvl_in   = lvl_ff;
      base_in  = base_ff;
      ia_in    = ia_ff;
      jb_in    = jb_ff;
      alen_in  = alen_ff;
      blen_in  = blen_ff;
      idx_in   = idx_ff;
      key_in   = key_ff;
      qhi_in   = qhi_ff;
      qi_in    = qi_ff;
      qk_in    = qk_ff;
      slo_in   = slo_ff;
      shi_in   = shi_ff;
      mid_in   = mid_ff;
      total_in = total_ff;
      kind_in  = kind_ff;
      case (state_ff)
         S_IDLE: begin
            if (acc) begin
               case (req_ch.mode)
                  rcl_pkg::MODE_BUILD: begin
                     n_in     = {1'b0, length};
                     idx_in   = '0;
                     state_in = S_CP_RD;
                  end
                  rcl_pkg::MODE_QUERY: begin
                     key_in   = req_ch.value ^ rcl_pkg::KEY_FLIP;
                     kind_in  = rcl_pkg::KIND_QUERY;
                     total_in = '0;
                     if (built_ff == '0) begin
                        state_in = S_DONE;
                     end else if ({2'b00, req_ch.range_low} > hi_clip) begin
                        state_in = S_DONE;
                     end else begin
                        qi_in    = {2'b00, req_ch.range_low};
                        qhi_in   = hi_clip;
                        qk_in    = '0;
                        state_in = S_Q_SIZE;
                     end
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_CP_RD: begin
            state_in = S_CP_WR;
         end
         S_CP_WR: begin
            idx_in = idx_ff + CW'(1);
            if (idx_ff + CW'(1) == n_ff) begin
               lvl_in   = '0;
               state_in = S_MG_LVL;
            end else begin
               state_in = S_CP_RD;
            end
         end
         S_MG_LVL: begin
            if (half < n_ff) begin
               base_in  = '0;
               state_in = S_MG_BLK;
            end else begin
               built_in = n_ff;
               top_in   = lvl_ff;
               kind_in  = rcl_pkg::KIND_BUILD;
               total_in = '0;
               state_in = S_DONE;
            end
         end
         S_MG_BLK: begin
            if (base_ff >= n_ff) begin
               lvl_in   = lvl_ff + LW'(1);
               state_in = S_MG_LVL;
            end else begin
               ia_in    = '0;
               jb_in    = '0;
               alen_in  = a_len;
               blen_in  = b_rest;
               state_in = S_MG_RD;
            end
         end
         S_MG_RD: begin
            state_in = S_MG_WR;
         end
         S_MG_WR: begin
            if (take_b) begin
               jb_in = jb_ff + CW'(1);
            end else begin
               ia_in = ia_ff + CW'(1);
            end
            if (ia_ff + jb_ff + CW'(1) == alen_ff + blen_ff) begin
               base_in  = base_ff + (half << 1);
               state_in = S_MG_BLK;
            end else begin
               state_in = S_MG_RD;
            end
         end
         S_Q_SIZE: begin
            if ((qk_ff < top_ff) && ((qi_ff & (sz - CW'(1))) == '0) &&
                (qi_ff + sz - CW'(1) <= qhi_ff)) begin
               qk_in = qk_ff + LW'(1);
            end else begin
               slo_in   = '0;
               shi_in   = CW'(1) << qk_ff;
               state_in = S_Q_RD;
            end
         end
         S_Q_RD: begin
            if (slo_ff < shi_ff) begin
               mid_in   = mid_c;
               state_in = S_Q_CMP;
            end else begin
               total_in = total_ff + slo_ff[rcl_pkg::LEN_W-1:0];
               qi_in    = qi_next;
               qk_in    = '0;
               state_in = (qi_next > qhi_ff) ? S_DONE : S_Q_SIZE;
            end
         end
         S_Q_CMP: begin
            if (lvl_qa < key_ff) begin
               slo_in = mid_ff + CW'(1);
            end else begin
               shi_in = mid_ff;
            end
            state_in = S_Q_RD;
         end
         S_DONE: begin
            if (res_take) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         built_ff <= '0;
         top_ff   <= '0;
      end else begin
         state_ff <= state_in;
         built_ff <= built_in;
         top_ff   <= top_in;
      end
      n_ff     <= n_in;
      lvl_ff   <= lvl_in;
      base_ff  <= base_in;
      ia_ff    <= ia_in;
      jb_ff    <= jb_in;
      alen_ff  <= alen_in;
      blen_ff  <= blen_in;
      idx_ff   <= idx_in;
      key_ff   <= key_in;
      qhi_ff   <= qhi_in;
      qi_ff    <= qi_in;
      qk_ff    <= qk_in;
      slo_ff   <= slo_in;
      shi_ff   <= shi_in;
      mid_ff   <= mid_in;
      total_ff <= total_in;
      kind_ff  <= kind_in;
   end

   assign res.valid = (state_ff == S_DONE);
   assign res.kind  = kind_ff;
   assign res.count = total_ff;

endmodule

/* hdl/range_count_less_than_unit.sv */
`timescale 1ns / 1ps
// Merge sort tree over up to 1024 signed 32-bit elements. A load request
// writes one element and gives no response. A build request copies the
// first length elements into level 0 and merges them level by level, then
// returns a done response. A query request splits the range into aligned
// blocks and binary-searches each block in the stored level. One request is
// in work at a time; a finished response waits in an output register.
// Length writes take effect at the next build.
module range_count_less_than_unit (
   input  logic                       clock,
   input  logic                       reset,
   rcl_req_if.sink                    req_ch,
   rcl_rsp_if.source                  rsp_ch,
   input  logic                       csr_write_enable,
   input  logic [rcl_pkg::LEN_W-1:0]  csr_write_data
);

   logic [rcl_pkg::LEN_W-1:0] length_ff;
   logic                      rsp_valid_ff;
   logic                      rsp_kind_ff;
   logic [rcl_pkg::LEN_W-1:0] rsp_count_ff;
   logic                      rsp_free;
   rcl_pkg::result_type       eng_res;

   assign rsp_free = !rsp_valid_ff || rsp_ch.ready;

   rcl_engine u_engine (
      .clock    (clock),
      .reset    (reset),
      .req_ch   (req_ch),
      .length   (length_ff),
      .res_take (rsp_free),
      .res      (eng_res)
   );

   // Clamp length writes into 1..MAX_LEN
   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff <= rcl_pkg::LEN_W'(rcl_pkg::MAX_LEN);
      end else if (csr_write_enable) begin
         if (csr_write_data == '0) begin
            length_ff <= rcl_pkg::LEN_W'(1);
         end else if (csr_write_data > rcl_pkg::LEN_W'(rcl_pkg::MAX_LEN)) begin
            length_ff <= rcl_pkg::LEN_W'(rcl_pkg::MAX_LEN);
         end else begin
            length_ff <= csr_write_data;
         end
      end
   end

   // Hold the response until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_free) begin
         rsp_valid_ff <= eng_res.valid;
      end
      if (rsp_free && eng_res.valid) begin
         rsp_kind_ff  <= eng_res.kind;
         rsp_count_ff <= eng_res.count;
      end
   end

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.kind  = rsp_kind_ff;
   assign rsp_ch.count = rsp_count_ff;

   a_idle_not_done: assert property (@(posedge clock) disable iff (reset)
      req_ch.ready |-> !eng_res.valid)
      else $error("engine accepts a request while holding a result");

   a_build_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && (rsp_ch.kind == rcl_pkg::KIND_BUILD) |-> rsp_ch.count == '0)
      else $error("build response with nonzero count");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> rsp_ch.count <= rcl_pkg::LEN_W'(rcl_pkg::MAX_LEN))
      else $error("count above capacity");

   a_length_range: assert property (@(posedge clock) disable iff (reset)
      (length_ff != '0) && (length_ff <= rcl_pkg::LEN_W'(rcl_pkg::MAX_LEN)))
      else $error("length register out of range");

endmodule
